// ===== rtl/esapd_pkg.sv =====
`timescale 1ns / 1ps

package esapd_pkg;

	typedef enum logic [2:0] {
		PH_LEN_HI  = 3'd0,
		PH_LEN_LO  = 3'd1,
		PH_SHIFT   = 3'd2,
		PH_SAMPLE  = 3'd3,
		PH_ESC_HI  = 3'd4,
		PH_ESC_LO  = 3'd5,
		PH_SKIP    = 3'd6
	} phase_t;

	localparam logic [7:0] ESCAPE_CODE = 8'h80;

	typedef logic signed [15:0] sample_t;

endpackage

// ===== rtl/escaped_shift_audio_packet_decoder.sv =====
`timescale 1ns / 1ps

// Decodes a byte stream of length-prefixed audio packets into 16-bit samples,
// alternating left and right channel. One byte is taken per clock; a byte enters
// an input register and is then decoded by a single pass of logic (phase update,
// sign extension and shift) into the result register. Throughput is one byte per
// cycle except while the input stalls, which happens only while the result
// register holds a sample that the downstream side has not yet taken.
// A byte of 0x80 escapes a raw big-endian 16-bit sample carried in the next two
// bytes; any other sample byte is sign extended and shifted left by its channel's
// shift nibble. Samples missing from a short packet are not produced.
module escaped_shift_audio_packet_decoder #(
	parameter int PAIRS_PER_PACKET = 1024
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [7:0]                data_byte,
	input  logic                      data_valid,
	output logic                      data_stall,
	output esapd_pkg::sample_t        sample,
	output logic                      channel,
	output logic                      last_in_packet,
	output logic                      sample_valid,
	input  logic                      sample_stall
);

	localparam int SLOTS = 2 * PAIRS_PER_PACKET;
	localparam int IDX_W = $clog2(SLOTS + 1);
	localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(SLOTS - 1);
	localparam logic [IDX_W-1:0] END_SLOT  = IDX_W'(SLOTS);

	// input stage
	logic [7:0]  byte_s1;
	logic        valid_s1;

	// decoder state
	esapd_pkg::phase_t phase_q, phase_d;
	logic [15:0]       bytes_left_q, bytes_left_d;
	logic [3:0]        left_shift_q, left_shift_d;
	logic [3:0]        right_shift_q, right_shift_d;
	logic [IDX_W-1:0]  idx_q, idx_d;
	logic [7:0]        esc_q, esc_d;

	logic              out_free;
	logic              step;
	logic [15:0]       bl_dec;
	logic [IDX_W-1:0]  idx_inc;
	logic [3:0]        sh;
	logic [15:0]       ext;
	logic              emit;
	logic [15:0]       emit_value;
	logic              emit_last;

	assign out_free   = !sample_valid || !sample_stall;
	assign step       = valid_s1 && out_free;
	assign data_stall = valid_s1 && !out_free;
	assign bl_dec     = bytes_left_q - 16'd1;
	assign idx_inc    = idx_q + IDX_W'(1);
	assign sh         = idx_q[0] ? right_shift_q : left_shift_q;
	assign ext        = {{8{byte_s1[7]}}, byte_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!data_stall) begin
			valid_s1 <= data_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!data_stall && data_valid) begin
			byte_s1 <= data_byte;
		end
	end

	// next state
	always_comb begin
		phase_d       = phase_q;
		bytes_left_d  = bytes_left_q;
		left_shift_d  = left_shift_q;
		right_shift_d = right_shift_q;
		idx_d         = idx_q;
		esc_d         = esc_q;
		unique case (phase_q)
			esapd_pkg::PH_LEN_LO: begin
				bytes_left_d = {bytes_left_q[15:8], byte_s1};
				phase_d = ({bytes_left_q[15:8], byte_s1} == 16'd0) ?
					esapd_pkg::PH_LEN_HI : esapd_pkg::PH_SHIFT;
			end
			esapd_pkg::PH_SHIFT: begin
				left_shift_d  = byte_s1[7:4];
				right_shift_d = byte_s1[3:0];
				idx_d         = '0;
				bytes_left_d  = bl_dec;
				phase_d = (bl_dec == 16'd0) ? esapd_pkg::PH_LEN_HI : esapd_pkg::PH_SAMPLE;
			end
			esapd_pkg::PH_SAMPLE: begin
				bytes_left_d = bl_dec;
				if (byte_s1 == esapd_pkg::ESCAPE_CODE) begin
					phase_d = (bl_dec == 16'd0) ?
						esapd_pkg::PH_LEN_HI : esapd_pkg::PH_ESC_HI;
				end else begin
					idx_d = idx_inc;
					if (bl_dec == 16'd0)
						phase_d = esapd_pkg::PH_LEN_HI;
					else if (idx_inc == END_SLOT)
						phase_d = esapd_pkg::PH_SKIP;
					else
						phase_d = esapd_pkg::PH_SAMPLE;
				end
			end
			esapd_pkg::PH_ESC_HI: begin
				esc_d        = byte_s1;
				bytes_left_d = bl_dec;
				phase_d = (bl_dec == 16'd0) ? esapd_pkg::PH_LEN_HI : esapd_pkg::PH_ESC_LO;
			end
			esapd_pkg::PH_ESC_LO: begin
				bytes_left_d = bl_dec;
				idx_d        = idx_inc;
				if (bl_dec == 16'd0)
					phase_d = esapd_pkg::PH_LEN_HI;
				else if (idx_inc == END_SLOT)
					phase_d = esapd_pkg::PH_SKIP;
				else
					phase_d = esapd_pkg::PH_SAMPLE;
			end
			esapd_pkg::PH_SKIP: begin
				bytes_left_d = bl_dec;
				if (bl_dec == 16'd0)
					phase_d = esapd_pkg::PH_LEN_HI;
			end
			default: begin
				// length high byte, also taken for unused codes
				bytes_left_d = {byte_s1, 8'h00};
				phase_d      = esapd_pkg::PH_LEN_LO;
			end
		endcase
	end

	// outputs
	always_comb begin
		emit       = 1'b0;
		emit_value = ext << sh;
		unique case (phase_q)
			esapd_pkg::PH_SAMPLE: begin
				emit = (byte_s1 != esapd_pkg::ESCAPE_CODE);
			end
			esapd_pkg::PH_ESC_LO: begin
				emit       = 1'b1;
				emit_value = {esc_q, byte_s1};
			end
			default: begin
				emit = 1'b0;
			end
		endcase
		emit_last = (idx_q == LAST_SLOT) || (bl_dec == 16'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= esapd_pkg::PH_LEN_HI;
			bytes_left_q  <= '0;
			left_shift_q  <= '0;
			right_shift_q <= '0;
			idx_q         <= '0;
			esc_q         <= '0;
			sample_valid  <= 1'b0;
		end else begin
			if (step) begin
				phase_q       <= phase_d;
				bytes_left_q  <= bytes_left_d;
				left_shift_q  <= left_shift_d;
				right_shift_q <= right_shift_d;
				idx_q         <= idx_d;
				esc_q         <= esc_d;
			end
			if (out_free) begin
				sample_valid <= step && emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			sample         <= esapd_pkg::sample_t'(emit_value);
			channel        <= idx_q[0];
			last_in_packet <= emit_last;
		end
	end

endmodule

// ===== rtl/esapd_checker.sv =====
`timescale 1ns / 1ps

module esapd_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 data_valid,
	input logic                 data_stall,
	input logic signed [15:0]   sample,
	input logic                 channel,
	input logic                 last_in_packet,
	input logic                 sample_valid,
	input logic                 sample_stall
);

	// the input side only backs up behind a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		data_stall |-> (sample_valid && sample_stall))
		else $error("input stalled without a held result");

	// a result appearing from empty must come from an item taken in through the input register
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sample_valid) |-> $past(data_valid && !data_stall, 2))
		else $error("result without a matching input item");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_valid && sample_stall) |=>
			(sample_valid && $stable(sample) && $stable(channel) && $stable(last_in_packet)))
		else $error("stalled result changed");

endmodule

bind escaped_shift_audio_packet_decoder esapd_checker u_esapd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.data_valid     (data_valid),
	.data_stall     (data_stall),
	.sample         (sample),
	.channel        (channel),
	.last_in_packet (last_in_packet),
	.sample_valid   (sample_valid),
	.sample_stall   (sample_stall)
);

// ===== test/tb_escaped_shift_audio_packet_decoder.sv =====
`timescale 1ns / 1ps

typedef struct {
	logic [15:0] value;
	logic        chan;
	logic        last;
} audio_result_t;

class audio_scoreboard;
	localparam int SLOTS = 2 * 1024;

	// decoder state as seen from the byte stream
	esapd_pkg::phase_t ph;
	logic [15:0] remaining;
	logic [3:0]  lsh;
	logic [3:0]  rsh;
	int unsigned slot;
	logic [7:0]  esc_hi;

	audio_result_t expected_q[$];
	int errors;
	int n_packets;
	int n_samples;
	int n_escapes;
	int n_last;
	int n_skipped;

	function new();
		ph = esapd_pkg::PH_LEN_HI;
		remaining = '0;
		lsh = '0;
		rsh = '0;
		slot = 0;
		esc_hi = '0;
		errors = 0;
		n_packets = 0;
		n_samples = 0;
		n_escapes = 0;
		n_last = 0;
		n_skipped = 0;
	endfunction

	function void push_sample(logic [15:0] v);
		audio_result_t r;
		r.value = v;
		r.chan = slot[0];
		r.last = (slot == SLOTS - 1) || (remaining == 0);
		expected_q.push_back(r);
		slot++;
		if (remaining == 0)
			ph = esapd_pkg::PH_LEN_HI;
		else if (slot >= SLOTS)
			ph = esapd_pkg::PH_SKIP;
		else
			ph = esapd_pkg::PH_SAMPLE;
	endfunction

	// called once per accepted input item
	function void note_byte(logic [7:0] b);
		logic [15:0] ext;
		logic [15:0] v;
		logic [3:0]  sh;
		case (ph)
			esapd_pkg::PH_LEN_LO: begin
				remaining = {remaining[15:8], b};
				ph = (remaining == 0) ? esapd_pkg::PH_LEN_HI : esapd_pkg::PH_SHIFT;
				n_packets++;
			end
			esapd_pkg::PH_SHIFT: begin
				lsh = b[7:4];
				rsh = b[3:0];
				slot = 0;
				remaining--;
				ph = (remaining == 0) ? esapd_pkg::PH_LEN_HI : esapd_pkg::PH_SAMPLE;
			end
			esapd_pkg::PH_SAMPLE: begin
				remaining--;
				if (b == esapd_pkg::ESCAPE_CODE) begin
					n_escapes++;
					ph = (remaining == 0) ? esapd_pkg::PH_LEN_HI : esapd_pkg::PH_ESC_HI;
				end else begin
					sh = slot[0] ? rsh : lsh;
					ext = {{8{b[7]}}, b};
					v = ext << sh;
					push_sample(v);
				end
			end
			esapd_pkg::PH_ESC_HI: begin
				esc_hi = b;
				remaining--;
				ph = (remaining == 0) ? esapd_pkg::PH_LEN_HI : esapd_pkg::PH_ESC_LO;
			end
			esapd_pkg::PH_ESC_LO: begin
				remaining--;
				push_sample({esc_hi, b});
			end
			esapd_pkg::PH_SKIP: begin
				remaining--;
				n_skipped++;
				if (remaining == 0)
					ph = esapd_pkg::PH_LEN_HI;
			end
			default: begin
				remaining = {b, 8'h00};
				ph = esapd_pkg::PH_LEN_LO;
			end
		endcase
	endfunction

	task report(string msg);
		errors++;
		$display("ERROR @%0t: %s", $time, msg);
	endtask

	task check_sample(logic [15:0] s, logic ch, logic last);
		audio_result_t r;
		if (expected_q.size() == 0) begin
			report($sformatf("unexpected sample %0d ch %0d last %0d", $signed(s), ch, last));
		end else begin
			r = expected_q.pop_front();
			n_samples++;
			if (last)
				n_last++;
			if (s !== r.value)
				report($sformatf("sample %0d, expected %0d", $signed(s), $signed(r.value)));
			if (ch !== r.chan)
				report($sformatf("channel %0d, expected %0d", ch, r.chan));
			if (last !== r.last)
				report($sformatf("last_in_packet %0d, expected %0d", last, r.last));
		end
	endtask
endclass

module tb_escaped_shift_audio_packet_decoder;
	localparam int PAIRS = 1024;
	localparam int SLOTS = 2 * PAIRS;
	localparam int STALL_LIMIT = 3000;
	localparam int HOLD_CYCLES = 400;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic [7:0]  data_byte = '0;
	logic        data_valid = 1'b0;
	logic        data_stall;
	esapd_pkg::sample_t sample;
	logic        channel;
	logic        last_in_packet;
	logic        sample_valid;
	logic        sample_stall = 1'b0;

	audio_scoreboard sb = new();

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_left = 0;
	int items_sent = 0;
	int quiet_cycles = 0;

	escaped_shift_audio_packet_decoder #(
		.PAIRS_PER_PACKET(PAIRS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.data_byte(data_byte),
		.data_valid(data_valid),
		.data_stall(data_stall),
		.sample(sample),
		.channel(channel),
		.last_in_packet(last_in_packet),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall)
	);

	always #4 clk = ~clk;

	// receiver: random stalls, or a long hold-off when requested
	always @(negedge clk) begin
		if (hold_left > 0) begin
			sample_stall <= 1'b1;
			hold_left--;
		end else begin
			sample_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && sample_valid && !sample_stall)
			sb.check_sample(sample, channel, last_in_packet);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((data_valid && !data_stall) || (sample_valid && !sample_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("timeout: no item moved for %0d cycles", STALL_LIMIT);
				$display("tb_escaped_shift_audio_packet_decoder failed");
				$finish;
			end
		end
	end

	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			data_valid <= 1'b0;
			@(negedge clk);
		end
		data_valid <= 1'b1;
		data_byte <= b;
		@(posedge clk);
		while (data_stall)
			@(posedge clk);
		sb.note_byte(b);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_packet(input logic [15:0] len, input int esc_pct, input bit plain);
		logic [7:0] b;
		send_byte(len[15:8]);
		send_byte(len[7:0]);
		if (len != 0)
			send_byte(8'($urandom_range(255)));
		for (int i = 1; i < len; i++) begin
			b = 8'($urandom_range(255));
			if (plain && b == esapd_pkg::ESCAPE_CODE)
				b = 8'h7F;
			else if (!plain && $urandom_range(99) < esc_pct)
				b = esapd_pkg::ESCAPE_CODE;
			send_byte(b);
		end
	endtask

	task automatic wait_drained();
		data_valid <= 1'b0;
		@(negedge clk);
		while (sb.expected_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic run_random(input int n);
		int stop_at;
		stop_at = items_sent + n;
		while (items_sent < stop_at) begin
			if ($urandom_range(99) < 80) begin
				if ($urandom_range(99) < 70)
					send_packet(16'($urandom_range(20)), 15, 1'b0);
				else
					send_packet(16'($urandom_range(80, 21)), 15, 1'b0);
			end else begin
				// short or empty packets, escape heavy, often cut mid-escape
				send_packet(16'($urandom_range(3)), 50, 1'b0);
			end
		end
	endtask

	initial begin
		logic [7:0] directed_q[$];
		directed_q = {
			8'h00, 8'h00,
			8'h00, 8'h01, 8'hF0,
			8'h00, 8'h07, 8'h4F, 8'h7F, esapd_pkg::ESCAPE_CODE, 8'h80, 8'h00, 8'hFF,
			esapd_pkg::ESCAPE_CODE,
			8'h00, 8'h03, 8'h0F, 8'h01, 8'h01,
			8'h00, 8'h03, 8'h00, esapd_pkg::ESCAPE_CODE, 8'h12
		};

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_idle_pct = 25;
		recv_idle_pct = 72;
		foreach (directed_q[i])
			send_byte(directed_q[i]);
		run_random(100);
		wait_drained();

		send_idle_pct = 72;
		recv_idle_pct = 25;
		run_random(100);
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		// fill every sample slot, then a few skipped bytes; receiver held off
		hold_left = HOLD_CYCLES;
		send_packet(16'(1 + SLOTS + 6), 0, 1'b1);
		run_random(30);

		// stream ends inside a packet whose declared length is near the maximum
		send_byte(8'hFF);
		send_byte(8'($urandom_range(255)));
		send_byte(8'($urandom_range(255)));
		repeat (5)
			send_byte(8'($urandom_range(255)));

		wait_drained();
		repeat (16) @(negedge clk);

		if (sb.expected_q.size() != 0)
			sb.report($sformatf("%0d samples never arrived", sb.expected_q.size()));
		$display("run: %0d bytes, %0d packets, %0d samples (%0d escaped, %0d packet ends)",
			items_sent, sb.n_packets, sb.n_samples, sb.n_escapes, sb.n_last);
		$display("run: %0d bytes skipped past a full packet, %0d mismatches",
			sb.n_skipped, sb.errors);
		if (sb.errors == 0)
			$display("tb_escaped_shift_audio_packet_decoder passed");
		else
			$display("tb_escaped_shift_audio_packet_decoder failed");
		$finish;
	end
endmodule
